### sv/assert_macros.svh
// Assertion macros used by the top-level RTL file of the dual-layout cache block.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define DLFC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define DLFC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/dlfc_pkg.sv
// Shared types and constants of the dual-layout FIFO cache block.
// No dependencies; imported by every module of the block but dlfc_queue.
`default_nettype none

package dlfc_pkg;

  // Default sizes of the top-level parameters
  localparam int DEF_ADDRESS_WIDTH = 48;
  localparam int DEF_MAX_SETS_LOG2 = 10;
  localparam int DEF_MAX_WAYS      = 8;

  // Counter and configuration port widths
  localparam int CNT_W     = 32;
  localparam int CFG_W     = 5;
  localparam int CFG_IDX_W = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_INDEX_BITS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_BITS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WAYS        = 2'd2;

  // Configuration reset values
  localparam logic [3:0] RST_INDEX_BITS  = 4'd5;
  localparam logic [4:0] RST_OFFSET_BITS = 5'd4;
  localparam logic [3:0] RST_WAYS        = 4'd1;

  typedef struct packed {
    logic [3:0] index_bits;
    logic [4:0] offset_bits;
    logic [3:0] ways;
  } cfg_t;

  // Per-cycle command from the back-end sequencer to a cache bank
  typedef struct packed {
    logic rd_en;   // read the set addressed by the request
    logic upd_en;  // compare and allocate on a miss
    logic clr_en;  // clear valid bits and victim pointer of one set
  } bank_ctl_t;

endpackage

`default_nettype wire

### sv/dual_layout_fifo_cache_sim.sv
// Dual-layout FIFO cache top level: config registers, front end, back end.
// An accepted access passes through the queue, the bank read registers and the output register.
// The back end takes a new transaction only after the read and write-back of the previous
// one's set in the tag and metadata memories of each bank, and waits while the output stalls.
// Reset: synchronous; then a clearing pass over all 2**MAX_SETS_LOG2 sets (1024 by
// default) zeroes valid bits and victim pointers while in_stall stays high.
`default_nettype none
`include "assert_macros.svh"

module dual_layout_fifo_cache_sim import dlfc_pkg::*; #(
  parameter int ADDRESS_WIDTH = DEF_ADDRESS_WIDTH,
  parameter int MAX_SETS_LOG2 = DEF_MAX_SETS_LOG2,
  parameter int MAX_WAYS      = DEF_MAX_WAYS
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     cfg_we,
  input  wire logic [CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [CFG_W-1:0]         cfg_wdata,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic [ADDRESS_WIDTH-1:0] in_address,
  input  wire logic                     in_is_write,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic                          out_hit_a,
  output logic                          out_hit_b,
  output logic [CNT_W-1:0]              out_mem_reads_a,
  output logic [CNT_W-1:0]              out_mem_reads_b,
  output logic [CNT_W-1:0]              out_mem_writes
);

  localparam int SET_W   = (MAX_SETS_LOG2 > 0) ? MAX_SETS_LOG2 : 1;
  localparam int ENTRY_W = 2 * ADDRESS_WIDTH + 2 * SET_W + 1;

  cfg_t               cfg_r;
  logic               q_valid, q_pop, clearing;
  logic [ENTRY_W-1:0] q_data;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.index_bits  <= RST_INDEX_BITS;
      cfg_r.offset_bits <= RST_OFFSET_BITS;
      cfg_r.ways        <= RST_WAYS;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_INDEX_BITS:  cfg_r.index_bits  <= cfg_wdata[3:0];
        REG_OFFSET_BITS: cfg_r.offset_bits <= cfg_wdata;
        REG_WAYS:        cfg_r.ways        <= cfg_wdata[3:0];
        default: begin
        end
      endcase
    end
  end

  dlfc_front #(
    .ADDRESS_WIDTH (ADDRESS_WIDTH),
    .MAX_SETS_LOG2 (MAX_SETS_LOG2)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .blocked     (clearing),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_address  (in_address),
    .in_is_write (in_is_write),
    .q_pop       (q_pop),
    .q_valid     (q_valid),
    .q_data      (q_data)
  );

  dlfc_back #(
    .ADDRESS_WIDTH (ADDRESS_WIDTH),
    .MAX_SETS_LOG2 (MAX_SETS_LOG2),
    .MAX_WAYS      (MAX_WAYS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .q_valid         (q_valid),
    .q_data          (q_data),
    .q_pop           (q_pop),
    .clearing        (clearing),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_hit_a       (out_hit_a),
    .out_hit_b       (out_hit_b),
    .out_mem_reads_a (out_mem_reads_a),
    .out_mem_reads_b (out_mem_reads_b),
    .out_mem_writes  (out_mem_writes)
  );

  // No result may come out of the clearing pass
  `DLFC_ASSERT_IMP(a_no_result_in_clear, clk, rst_n, clearing, !out_valid && !q_pop, "result during clear pass")
  // Nothing enters the queue while the sets are being cleared
  `DLFC_ASSERT_IMP(a_no_accept_in_clear, clk, rst_n, clearing, !q_valid, "queued transaction during clear pass")
  // Miss counts never fall from one result to the next
  `DLFC_ASSERT_NXT(a_reads_a_mono, clk, rst_n, out_valid && !out_stall, !out_valid || out_mem_reads_a >= $past(out_mem_reads_a), "cache A miss count fell")
  `DLFC_ASSERT_NXT(a_reads_b_mono, clk, rst_n, out_valid && !out_stall, !out_valid || out_mem_reads_b >= $past(out_mem_reads_b), "cache B miss count fell")

endmodule

`default_nettype wire

### sv/dlfc_queue.sv
// Two-entry register queue between the front end and the back end.
// Depends on nothing but its WIDTH parameter.
`default_nettype none

module dlfc_queue #(
  parameter int WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  full,
  input  wire logic             pop,
  output logic                  not_empty,
  output logic [WIDTH-1:0]      head
);

  logic [WIDTH-1:0] slot_r [2];
  logic             wr_ptr_r, wr_ptr_nxt;
  logic             rd_ptr_r, rd_ptr_nxt;
  logic [1:0]       count_r, count_nxt;

  assign full      = (count_r == 2'd2);
  assign not_empty = (count_r != 2'd0);
  assign head      = slot_r[rd_ptr_r];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store pushed entry
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

### sv/dlfc_front.sv
// Front end: accepts accesses, splits the address for both cache layouts
// and queues the result. Depends on dlfc_pkg and dlfc_queue.
`default_nettype none

module dlfc_front import dlfc_pkg::*; #(
  parameter int ADDRESS_WIDTH = DEF_ADDRESS_WIDTH,
  parameter int MAX_SETS_LOG2 = DEF_MAX_SETS_LOG2,
  localparam int SET_W   = (MAX_SETS_LOG2 > 0) ? MAX_SETS_LOG2 : 1,
  localparam int ENTRY_W = 2 * ADDRESS_WIDTH + 2 * SET_W + 1
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire cfg_t                     cfg,
  input  wire logic                     blocked,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic [ADDRESS_WIDTH-1:0] in_address,
  input  wire logic                     in_is_write,
  input  wire logic                     q_pop,
  output logic                          q_valid,
  output logic [ENTRY_W-1:0]            q_data
);

  localparam int SH_W = $clog2(ADDRESS_WIDTH + 1);

  logic [SH_W-1:0]          ib_sh, ob_sh, room_sh, tb_sh;
  logic [ADDRESS_WIDTH-1:0] idx_mask, tag_mask, addr_ob;
  logic [ADDRESS_WIDTH-1:0] tag_a, tag_b;
  logic [SET_W-1:0]         set_a, set_b;
  logic                     q_full, push;

  // Clamp field widths to what the storage holds
  always_comb begin
    ib_sh   = (cfg.index_bits > MAX_SETS_LOG2) ? SH_W'(MAX_SETS_LOG2)
                                                : SH_W'(cfg.index_bits);
    room_sh = SH_W'(ADDRESS_WIDTH) - ib_sh;
    ob_sh   = (SH_W'(cfg.offset_bits) > room_sh) ? room_sh : SH_W'(cfg.offset_bits);
    tb_sh   = room_sh - ob_sh;
  end

  // Split the address: A is tag|index|offset, B is index|tag|offset
  always_comb begin
    idx_mask = {ADDRESS_WIDTH{1'b1}} >> (SH_W'(ADDRESS_WIDTH) - ib_sh);
    tag_mask = {ADDRESS_WIDTH{1'b1}} >> (SH_W'(ADDRESS_WIDTH) - tb_sh);
    addr_ob  = in_address >> ob_sh;
    set_a    = SET_W'(addr_ob & idx_mask);
    tag_a    = (in_address >> (ob_sh + ib_sh)) & tag_mask;
    set_b    = SET_W'((in_address >> (SH_W'(ADDRESS_WIDTH) - ib_sh)) & idx_mask);
    tag_b    = addr_ob & tag_mask;
  end

  assign in_stall = q_full || blocked;
  assign push     = in_valid && !in_stall;

  dlfc_queue #(
    .WIDTH (ENTRY_W)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data ({in_is_write, tag_b, set_b, tag_a, set_a}),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .head      (q_data)
  );

endmodule

`default_nettype wire

### sv/dlfc_bank.sv
// One set-associative cache bank: tag and per-set metadata memories,
// parallel way compare and FIFO allocation. Depends on dlfc_pkg.
`default_nettype none

module dlfc_bank import dlfc_pkg::*; #(
  parameter int ADDRESS_WIDTH = DEF_ADDRESS_WIDTH,
  parameter int MAX_SETS_LOG2 = DEF_MAX_SETS_LOG2,
  parameter int MAX_WAYS      = DEF_MAX_WAYS,
  localparam int SET_W = (MAX_SETS_LOG2 > 0) ? MAX_SETS_LOG2 : 1,
  localparam int WN_W  = $clog2(MAX_WAYS + 1)
) (
  input  wire logic                     clk,
  input  wire bank_ctl_t                ctl,
  input  wire logic [SET_W-1:0]         clr_set,
  input  wire logic [SET_W-1:0]         req_set,
  input  wire logic [ADDRESS_WIDTH-1:0] req_tag,
  input  wire logic [WN_W-1:0]          nways,
  output logic                          hit
);

  localparam int DEPTH  = 1 << MAX_SETS_LOG2;
  localparam int PTR_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int META_W = PTR_W + MAX_WAYS;
  localparam int ROW_W  = MAX_WAYS * ADDRESS_WIDTH;

  logic [ROW_W-1:0]  tag_mem  [DEPTH];
  logic [META_W-1:0] meta_mem [DEPTH];

  logic [ROW_W-1:0]         tag_row_r, tag_row_nxt;
  logic [META_W-1:0]        meta_r;
  logic [SET_W-1:0]         set_r;
  logic [ADDRESS_WIDTH-1:0] tag_r;

  logic [MAX_WAYS-1:0] valid_q, valid_nxt, match;
  logic [PTR_W-1:0]    ptr_q, vic, ptr_nxt;
  logic [WN_W-1:0]     ptr_inc;
  logic                tag_we, meta_we;
  logic [SET_W-1:0]    meta_wa;
  logic [META_W-1:0]   meta_wd;

  // Read one set; hold request for the update cycle
  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      tag_row_r <= tag_mem[req_set];
      meta_r    <= meta_mem[req_set];
      set_r     <= req_set;
      tag_r     <= req_tag;
    end
  end

  assign valid_q = meta_r[MAX_WAYS-1:0];
  assign ptr_q   = meta_r[META_W-1 -: PTR_W];

  // Compare all enabled ways at once
  always_comb begin
    for (int w = 0; w < MAX_WAYS; w++) begin
      match[w] = valid_q[w] && (WN_W'(w) < nways) &&
                 (tag_row_r[w*ADDRESS_WIDTH +: ADDRESS_WIDTH] == tag_r);
    end
  end

  assign hit = |match;

  // Pick the oldest line and advance the round-robin pointer
  always_comb begin
    vic     = (WN_W'(ptr_q) >= nways) ? '0 : ptr_q;
    ptr_inc = WN_W'(vic) + WN_W'(1);
    ptr_nxt = (ptr_inc >= nways) ? '0 : PTR_W'(ptr_inc);
    for (int w = 0; w < MAX_WAYS; w++) begin
      tag_row_nxt[w*ADDRESS_WIDTH +: ADDRESS_WIDTH] =
        (PTR_W'(w) == vic) ? tag_r : tag_row_r[w*ADDRESS_WIDTH +: ADDRESS_WIDTH];
      valid_nxt[w] = valid_q[w] || (PTR_W'(w) == vic);
    end
  end

  // Write back on a miss, or clear metadata during the reset pass
  always_comb begin
    tag_we  = ctl.upd_en && !hit;
    meta_we = ctl.clr_en || tag_we;
    meta_wa = ctl.clr_en ? clr_set : set_r;
    meta_wd = ctl.clr_en ? '0 : {ptr_nxt, valid_nxt};
  end

  always_ff @(posedge clk) begin
    if (tag_we) begin
      tag_mem[set_r] <= tag_row_nxt;
    end
    if (meta_we) begin
      meta_mem[meta_wa] <= meta_wd;
    end
  end

endmodule

`default_nettype wire

### sv/dlfc_back.sv
// Back end: sequences lookups in both banks, keeps the saturating counters
// and drives the output register. Depends on dlfc_pkg and dlfc_bank.
`default_nettype none

module dlfc_back import dlfc_pkg::*; #(
  parameter int ADDRESS_WIDTH = DEF_ADDRESS_WIDTH,
  parameter int MAX_SETS_LOG2 = DEF_MAX_SETS_LOG2,
  parameter int MAX_WAYS      = DEF_MAX_WAYS,
  localparam int SET_W   = (MAX_SETS_LOG2 > 0) ? MAX_SETS_LOG2 : 1,
  localparam int ENTRY_W = 2 * ADDRESS_WIDTH + 2 * SET_W + 1
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire cfg_t               cfg,
  input  wire logic               q_valid,
  input  wire logic [ENTRY_W-1:0] q_data,
  output logic                    q_pop,
  output logic                    clearing,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    out_hit_a,
  output logic                    out_hit_b,
  output logic [CNT_W-1:0]        out_mem_reads_a,
  output logic [CNT_W-1:0]        out_mem_reads_b,
  output logic [CNT_W-1:0]        out_mem_writes
);

  localparam int DEPTH = 1 << MAX_SETS_LOG2;
  localparam int WN_W  = $clog2(MAX_WAYS + 1);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_LOOK  = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [SET_W-1:0] clr_idx_r;
  logic             clr_last;
  logic             is_write_r;
  logic             out_free, done;
  bank_ctl_t        ctl;
  logic [WN_W-1:0]  nways;
  logic             hit_a, hit_b;

  logic [CNT_W-1:0] cnt_a_r, cnt_b_r, cnt_w_r;
  logic [CNT_W-1:0] cnt_a_nxt, cnt_b_nxt, cnt_w_nxt;
  logic             out_valid_r, hit_a_r, hit_b_r;
  logic [CNT_W-1:0] reads_a_r, reads_b_r, writes_r;

  logic [SET_W-1:0]         set_a, set_b;
  logic [ADDRESS_WIDTH-1:0] tag_a, tag_b;

  // Unpack the queued transaction
  assign set_a = q_data[SET_W-1:0];
  assign tag_a = q_data[SET_W +: ADDRESS_WIDTH];
  assign set_b = q_data[SET_W+ADDRESS_WIDTH +: SET_W];
  assign tag_b = q_data[2*SET_W+ADDRESS_WIDTH +: ADDRESS_WIDTH];

  // Clamp associativity to one through MAX_WAYS
  always_comb begin
    if (cfg.ways == 4'd0) begin
      nways = WN_W'(1);
    end else if (cfg.ways > MAX_WAYS) begin
      nways = WN_W'(MAX_WAYS);
    end else begin
      nways = WN_W'(cfg.ways);
    end
  end

  assign out_free = !out_valid_r || !out_stall;
  assign clr_last = (clr_idx_r == SET_W'(DEPTH - 1));
  assign clearing = (state_r == ST_CLEAR);

  // Sequence: clear pass, then read set, then compare and write back
  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    q_pop     = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        ctl.clr_en = 1'b1;
        if (clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          ctl.rd_en  = 1'b1;
          state_nxt  = ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (out_free) begin
          ctl.upd_en = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  assign done = ctl.upd_en;

  dlfc_bank #(
    .ADDRESS_WIDTH (ADDRESS_WIDTH),
    .MAX_SETS_LOG2 (MAX_SETS_LOG2),
    .MAX_WAYS      (MAX_WAYS)
  ) u_bank_a (
    .clk     (clk),
    .ctl     (ctl),
    .clr_set (clr_idx_r),
    .req_set (set_a),
    .req_tag (tag_a),
    .nways   (nways),
    .hit     (hit_a)
  );

  dlfc_bank #(
    .ADDRESS_WIDTH (ADDRESS_WIDTH),
    .MAX_SETS_LOG2 (MAX_SETS_LOG2),
    .MAX_WAYS      (MAX_WAYS)
  ) u_bank_b (
    .clk     (clk),
    .ctl     (ctl),
    .clr_set (clr_idx_r),
    .req_set (set_b),
    .req_tag (tag_b),
    .nways   (nways),
    .hit     (hit_b)
  );

  // Saturating counters including the current transaction
  always_comb begin
    cnt_a_nxt = (!hit_a && (cnt_a_r != '1)) ? cnt_a_r + CNT_W'(1) : cnt_a_r;
    cnt_b_nxt = (!hit_b && (cnt_b_r != '1)) ? cnt_b_r + CNT_W'(1) : cnt_b_r;
    cnt_w_nxt = (is_write_r && (cnt_w_r != '1)) ? cnt_w_r + CNT_W'(1) : cnt_w_r;
  end

  // Control state and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_idx_r   <= '0;
      cnt_a_r     <= '0;
      cnt_b_r     <= '0;
      cnt_w_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (ctl.clr_en) begin
        clr_idx_r <= clr_idx_r + SET_W'(1);
      end
      if (done) begin
        cnt_a_r     <= cnt_a_nxt;
        cnt_b_r     <= cnt_b_nxt;
        cnt_w_r     <= cnt_w_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Hold the write flag and load the result register
  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      is_write_r <= q_data[ENTRY_W-1];
    end
    if (done) begin
      hit_a_r   <= hit_a;
      hit_b_r   <= hit_b;
      reads_a_r <= cnt_a_nxt;
      reads_b_r <= cnt_b_nxt;
      writes_r  <= cnt_w_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_hit_a       = hit_a_r;
  assign out_hit_b       = hit_b_r;
  assign out_mem_reads_a = reads_a_r;
  assign out_mem_reads_b = reads_b_r;
  assign out_mem_writes  = writes_r;

endmodule

`default_nettype wire

### tb/dlfc_checker.sv
// Scoreboard for the dual-layout FIFO cache: tracks config writes, predicts
// each access result in both cache layouts and compares the outputs.
// Depends on dlfc_pkg for widths, register indexes and reset values.
module dlfc_checker import dlfc_pkg::*; #(
  parameter int ADDRESS_WIDTH = DEF_ADDRESS_WIDTH,
  parameter int MAX_SETS_LOG2 = DEF_MAX_SETS_LOG2,
  parameter int MAX_WAYS      = DEF_MAX_WAYS
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_W-1:0]         cfg_wdata,
  input  logic                     in_valid,
  input  logic                     in_stall,
  input  logic [ADDRESS_WIDTH-1:0] in_address,
  input  logic                     in_is_write,
  input  logic                     out_valid,
  input  logic                     out_stall,
  input  logic                     out_hit_a,
  input  logic                     out_hit_b,
  input  logic [CNT_W-1:0]         out_mem_reads_a,
  input  logic [CNT_W-1:0]         out_mem_reads_b,
  input  logic [CNT_W-1:0]         out_mem_writes,
  output int                       fail_count,
  output int                       pending,
  output int                       hits_a,
  output int                       hits_b
);

  localparam int SETS   = 1 << MAX_SETS_LOG2;
  localparam int LINES  = SETS * MAX_WAYS;
  localparam int BANK_A = 0;
  localparam int BANK_B = 1;

  typedef struct packed {
    logic             hit_a;
    logic             hit_b;
    logic [CNT_W-1:0] reads_a;
    logic [CNT_W-1:0] reads_b;
    logic [CNT_W-1:0] writes;
  } access_result_t;

  // Shadow copy of the configuration and of both tag stores
  cfg_t                     cache_cfg;
  bit                       line_valid [2][LINES];
  logic [ADDRESS_WIDTH-1:0] line_tag   [2][LINES];
  int unsigned              victim     [2][SETS];
  logic [CNT_W-1:0]         miss_count [2];
  logic [CNT_W-1:0]         write_count;
  access_result_t           result_queue [$];

  function automatic logic [63:0] low_mask(int n);
    return (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
  endfunction

  function automatic logic [CNT_W-1:0] sat_inc(logic [CNT_W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  // Look up one set; on a miss fill the FIFO victim way and advance the pointer
  function automatic bit lookup_bank(int bank, int set_idx,
                                     logic [ADDRESS_WIDTH-1:0] tag, int nways);
    int base;
    int v;
    base = (set_idx % SETS) * MAX_WAYS;
    for (int w = 0; w < nways; w++) begin
      if (line_valid[bank][base+w] && line_tag[bank][base+w] == tag) return 1'b1;
    end
    v = victim[bank][set_idx % SETS];
    if (v >= nways) v = 0;
    line_valid[bank][base+v] = 1'b1;
    line_tag[bank][base+v]   = tag;
    v++;
    if (v >= nways) v = 0;
    victim[bank][set_idx % SETS] = v;
    miss_count[bank] = sat_inc(miss_count[bank]);
    return 1'b0;
  endfunction

  // Split the address both ways, clamp the config, and update both caches
  function automatic access_result_t predict_access(logic [ADDRESS_WIDTH-1:0] addr,
                                                    logic is_write);
    int ib;
    int ob;
    int nw;
    int tb;
    int set_a;
    int set_b;
    logic [63:0] a64;
    logic [63:0] tmask;
    logic [ADDRESS_WIDTH-1:0] tag_a;
    logic [ADDRESS_WIDTH-1:0] tag_b;
    access_result_t r;
    ib = cache_cfg.index_bits;
    ob = cache_cfg.offset_bits;
    nw = cache_cfg.ways;
    if (ib > MAX_SETS_LOG2) ib = MAX_SETS_LOG2;
    if (ib > ADDRESS_WIDTH) ib = ADDRESS_WIDTH;
    if (ob > ADDRESS_WIDTH - ib) ob = ADDRESS_WIDTH - ib;
    if (nw == 0) nw = 1;
    if (nw > MAX_WAYS) nw = MAX_WAYS;
    tb    = ADDRESS_WIDTH - ib - ob;
    tmask = low_mask(tb);
    a64   = addr;
    set_a = int'((a64 >> ob) & low_mask(ib));
    tag_a = ADDRESS_WIDTH'((a64 >> (ob + ib)) & tmask);
    set_b = int'((a64 >> (ADDRESS_WIDTH - ib)) & low_mask(ib));
    tag_b = ADDRESS_WIDTH'((a64 >> ob) & tmask);
    r.hit_a = lookup_bank(BANK_A, set_a, tag_a, nw);
    r.hit_b = lookup_bank(BANK_B, set_b, tag_b, nw);
    if (is_write) write_count = sat_inc(write_count);
    r.reads_a = miss_count[BANK_A];
    r.reads_b = miss_count[BANK_B];
    r.writes  = write_count;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [CNT_W-1:0] exp_v,
                             input logic [CNT_W-1:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t mismatch %s: expected %0d, actual %0d", $time, name, exp_v, act_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    access_result_t expected;
    if (!rst_n) begin
      // Clear the shadow state
      for (int i = 0; i < LINES; i++) begin
        line_valid[BANK_A][i] = 1'b0;
        line_valid[BANK_B][i] = 1'b0;
      end
      for (int i = 0; i < SETS; i++) begin
        victim[BANK_A][i] = 0;
        victim[BANK_B][i] = 0;
      end
      miss_count[BANK_A] = '0;
      miss_count[BANK_B] = '0;
      write_count = '0;
      cache_cfg = '{index_bits: RST_INDEX_BITS, offset_bits: RST_OFFSET_BITS,
                    ways: RST_WAYS};
      result_queue.delete();
      fail_count = 0;
      hits_a = 0;
      hits_b = 0;
    end else begin
      // Compare a delivered result with the oldest prediction
      if (out_valid && !out_stall) begin
        if (result_queue.size() == 0) begin
          $display("%0t unexpected result: expected none, actual hit_a=%0b hit_b=%0b",
                   $time, out_hit_a, out_hit_b);
          fail_count++;
        end else begin
          expected = result_queue.pop_front();
          check_field("hit_a", expected.hit_a, out_hit_a);
          check_field("hit_b", expected.hit_b, out_hit_b);
          check_field("mem_reads_a", expected.reads_a, out_mem_reads_a);
          check_field("mem_reads_b", expected.reads_b, out_mem_reads_b);
          check_field("mem_writes", expected.writes, out_mem_writes);
          if (expected.hit_a) hits_a++;
          if (expected.hit_b) hits_b++;
        end
      end
      // Track register writes
      if (cfg_we) begin
        case (cfg_index)
          REG_INDEX_BITS:  cache_cfg.index_bits  = cfg_wdata[3:0];
          REG_OFFSET_BITS: cache_cfg.offset_bits = cfg_wdata;
          REG_WAYS:        cache_cfg.ways        = cfg_wdata[3:0];
          default: ;
        endcase
      end
      // Predict each accepted access
      if (in_valid && !in_stall) begin
        result_queue.push_back(predict_access(in_address, in_is_write));
      end
    end
    pending = result_queue.size();
  end

endmodule

### tb/tb_dual_layout_fifo_cache_sim.sv
// Top of the dual-layout FIFO cache testbench: clock, reset, access stimulus,
// config phases, output stalls, watchdog and verdict.
// Depends on dlfc_pkg, dual_layout_fifo_cache_sim and dlfc_checker.
module tb_dual_layout_fifo_cache_sim;
  import dlfc_pkg::*;

  localparam int AW              = DEF_ADDRESS_WIDTH;
  localparam int POOL            = 12;
  localparam int FIXED_PHASES    = 10;
  localparam int PHASES          = 13;
  localparam int ITEMS_PER_PHASE = 140;
  localparam int HOLD_PHASE      = 3;
  localparam int PAUSE_PHASE     = 5;
  localparam int HOLD_CYCLES     = 300;
  localparam int DRAIN_CYCLES    = 8;
  localparam int IDLE_LIMIT      = 6000;
  localparam int DIRECTED        = 14;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;
  logic                 in_valid;
  logic                 in_stall;
  logic [AW-1:0]        in_address;
  logic                 in_is_write;
  logic                 out_valid;
  logic                 out_stall;
  logic                 out_hit_a;
  logic                 out_hit_b;
  logic [CNT_W-1:0]     out_mem_reads_a;
  logic [CNT_W-1:0]     out_mem_reads_b;
  logic [CNT_W-1:0]     out_mem_writes;

  int fail_count;
  int pending;
  int hits_a;
  int hits_b;
  int n_sent;
  int hold_req;
  bit quiet;

  logic [AW-1:0] addr_pool [POOL];

  // Default-config accesses: block reuse, conflicts in both layouts, extremes
  logic [AW-1:0] dir_addr [DIRECTED] = '{
    48'h0000_0000_0000, 48'h0000_0000_0000, 48'h0000_0000_000F, 48'h0000_0000_0010,
    48'h0000_0000_0200, 48'h0000_0000_0000, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF,
    48'h8000_0000_0000, 48'hAAAA_AAAA_AAAA, 48'h5555_5555_5555, 48'hAAAA_AAAA_AAAA,
    48'h8000_0000_0000, 48'h0000_0000_01F0};
  bit dir_write [DIRECTED] = '{0, 1, 0, 0, 1, 0, 0, 1, 0, 1, 0, 0, 1, 0};

  // index_bits, offset_bits, ways; over-range values exercise the clamps
  int cfg_table [FIXED_PHASES][3] = '{
    '{0, 0, 1}, '{10, 16, 8}, '{15, 31, 15}, '{4, 2, 0}, '{2, 6, 8},
    '{2, 6, 3}, '{2, 6, 8}, '{10, 0, 2}, '{1, 4, 4}, '{5, 4, 1}};

  dual_layout_fifo_cache_sim DUT (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_address(in_address), .in_is_write(in_is_write),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_hit_a(out_hit_a), .out_hit_b(out_hit_b),
    .out_mem_reads_a(out_mem_reads_a), .out_mem_reads_b(out_mem_reads_b),
    .out_mem_writes(out_mem_writes)
  );

  dlfc_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_address(in_address), .in_is_write(in_is_write),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_hit_a(out_hit_a), .out_hit_b(out_hit_b),
    .out_mem_reads_a(out_mem_reads_a), .out_mem_reads_b(out_mem_reads_b),
    .out_mem_writes(out_mem_writes),
    .fail_count(fail_count), .pending(pending), .hits_a(hits_a), .hits_b(hits_b)
  );

  always #5 clk = ~clk;

  function automatic logic [AW-1:0] random_address();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[AW-1:0];
  endfunction

  // Mostly revisit recent blocks or near neighbors so both caches hit and evict
  function automatic logic [AW-1:0] next_address();
    int sel;
    int slot;
    logic [AW-1:0] a;
    logic [AW-1:0] one_hot;
    sel  = $urandom_range(0, 99);
    slot = $urandom_range(0, POOL - 1);
    if (sel < 45) begin
      a = addr_pool[slot];
    end else if (sel < 75) begin
      one_hot = '0;
      one_hot[$urandom_range(0, AW - 1)] = 1'b1;
      a = addr_pool[slot] ^ one_hot;
      if (sel < 60) addr_pool[$urandom_range(0, POOL - 1)] = a;
    end else begin
      a = random_address();
      addr_pool[slot] = a;
    end
    return a;
  endfunction

  // Offer one transaction and hold it until accepted
  task automatic send_access(input logic [AW-1:0] a, input logic w);
    in_valid    <= 1'b1;
    in_address  <= a;
    in_is_write <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    n_sent++;
  endtask

  task automatic idle_input();
    in_valid <= 1'b0;
    repeat ($urandom_range(1, 17)) @(negedge clk);
  endtask

  // Stop offering and wait for every predicted result, then let the pipe settle
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
  endtask

  // Stimulus and verdict
  initial begin
    int ib;
    int ob;
    int nw;
    clk         = 1'b0;
    rst_n       = 1'b0;
    cfg_we      = 1'b0;
    cfg_index   = REG_INDEX_BITS;
    cfg_wdata   = '0;
    in_valid    = 1'b0;
    in_address  = '0;
    in_is_write = 1'b0;
    out_stall   = 1'b0;
    n_sent      = 0;
    hold_req    = 0;
    quiet       = 1'b0;
    foreach (addr_pool[i]) addr_pool[i] = random_address();
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // Directed accesses under the reset configuration
    for (int i = 0; i < DIRECTED; i++) send_access(dir_addr[i], dir_write[i]);

    for (int p = 0; p < PHASES; p++) begin
      drain_results();
      if (p < FIXED_PHASES) begin
        ib = cfg_table[p][0];
        ob = cfg_table[p][1];
        nw = cfg_table[p][2];
      end else begin
        ib = $urandom_range(0, 15);
        ob = $urandom_range(0, 31);
        nw = $urandom_range(0, 15);
      end
      cfg_write(REG_INDEX_BITS, CFG_W'(ib));
      cfg_write(REG_OFFSET_BITS, CFG_W'(ob));
      cfg_write(REG_WAYS, CFG_W'(nw));
      cfg_we <= 1'b0;
      @(negedge clk);
      quiet = (p == PHASES - 1);
      if (p == HOLD_PHASE) hold_req++;
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        if (p == PAUSE_PHASE && k == ITEMS_PER_PHASE / 2) drain_results();
        else if (!quiet && $urandom_range(0, 11) == 0) idle_input();
        send_access(next_address(), 1'($urandom_range(0, 1)));
      end
    end
    drain_results();

    $display("covered %0d accesses over %0d cache settings plus the reset one",
             n_sent, PHASES);
    $display("hits seen: cache A %0d, cache B %0d", hits_a, hits_b);
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Output stall bursts, one long hold-off on request, none at the end
  initial begin
    int hold_seen;
    hold_seen = 0;
    @(negedge clk);
    forever begin
      if (hold_req != hold_seen) begin
        hold_seen++;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 17)) @(negedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 20)) @(negedge clk);
      end
    end
  end

  // Watchdog: abort when no transaction moves for too long
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
    $display("status: fail");
    $finish;
  end

endmodule
